// ===== src/shac_pkg.sv =====
// Shared types, constants and round constants of the SHA-512/384 core.
`timescale 1ns / 1ps
package shac_pkg;

    localparam int WORD_W = 64;
    localparam int ROUNDS = 80;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [3:0] LEN_SLOT = 4'd14;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_iv;
        logic       take_word;
        logic       push_pad;
        logic       start_round;
        logic       do_round;
        logic       do_add;
        logic       emit_step;
        logic       finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       block_full;
        logic       rounds_done;
        logic       pad_done;
        logic       pad_left;
        logic       emit_last;
    } stat_t;

    function automatic logic [63:0] round_const(input logic [6:0] i);
        logic [63:0] k;
        unique case (i)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] init_value(input logic sel, input logic [2:0] i);
        logic [63:0] v;
        unique case ({sel, i})
            4'd0: v = 64'h6a09e667f3bcc908; 4'd1: v = 64'hbb67ae8584caa73b;
            4'd2: v = 64'h3c6ef372fe94f82b; 4'd3: v = 64'ha54ff53a5f1d36f1;
            4'd4: v = 64'h510e527fade682d1; 4'd5: v = 64'h9b05688c2b3e6c1f;
            4'd6: v = 64'h1f83d9abfb41bd6b; 4'd7: v = 64'h5be0cd19137e2179;
            4'd8: v = 64'hcbbb9d5dc1059ed8; 4'd9: v = 64'h629a292a367cd507;
            4'd10: v = 64'h9159015a3070dd17; 4'd11: v = 64'h152fecd8f70e5939;
            4'd12: v = 64'h67332667ffc00b31; 4'd13: v = 64'h8eb44a8768581511;
            4'd14: v = 64'hdb0c2e0d64f98fa7; default: v = 64'h47b5481dbefa4fa4;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

// ===== src/shac_if.sv =====
// Request channel interfaces of the SHA-512/384 core.
`timescale 1ns / 1ps
interface shac_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        final_word;
    modport source (output valid, message_word, byte_count, final_word, input ready);
    modport sink (input valid, message_word, byte_count, final_word, output ready);
endinterface

interface shac_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_digest_word;
    modport source (output valid, digest_word, word_index, last_digest_word, input ready);
    modport sink (input valid, digest_word, word_index, last_digest_word, output ready);
endinterface

interface shac_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== src/shac_datapath.sv =====
// Datapath of the SHA-512/384 core: buffer, schedule, round unit, chain value.
`timescale 1ns / 1ps
module shac_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  shac_pkg::cmd_t      cmd,
    output shac_pkg::stat_t     stat,
    input  logic                variant,
    input  logic [63:0]         message_word,
    input  logic [3:0]          byte_count,
    input  logic                final_word,
    output logic [63:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_digest_word
);
    logic [63:0] w_reg [16];
    logic [63:0] v_reg [8];
    logic [63:0] h_reg [8];
    logic [63:0] len_reg, len_next;
    logic [3:0]  pos_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        n384_reg;
    logic        pend_reg;    // pad byte still owed after a full final word
    logic        padok_reg;   // pad byte already placed
    logic        zslot_reg;   // slot 14 of this block took a padding zero
    logic        lendone_reg; // length word pushed
    logic [3:0]  n_clip;
    logic [63:0] keep, in_word, pad_word, wi, s0, s1, t1, t2, ch, mj, sg0, sg1;
    logic [63:0] x15, x2;

    always_comb
    begin
        n_clip = (byte_count > 4'd8) ? 4'd8 : byte_count;
        if (!final_word)
            n_clip = 4'd8;
        keep = (n_clip == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {n_clip, 3'b000});
        in_word = message_word & keep;
        if (final_word && n_clip != 4'd8)
            in_word = in_word | ({shac_pkg::PAD_BYTE, 56'd0} >> {n_clip, 3'b000});
        len_next = len_reg + {60'd0, n_clip};
        // padding: owed pad byte, zeros, then length once slot 14 is free
        if (pend_reg)
            pad_word = {shac_pkg::PAD_BYTE, 56'd0};
        else if (pos_reg == 4'd15 && zslot_reg)
            pad_word = {len_reg[60:0], 3'b000};
        else
            pad_word = '0;
    end

    assign x15 = w_reg[1];
    assign x2  = w_reg[14];
    assign s0  = shac_pkg::rotr(x15, 1) ^ shac_pkg::rotr(x15, 8) ^ (x15 >> 7);
    assign s1  = shac_pkg::rotr(x2, 19) ^ shac_pkg::rotr(x2, 61) ^ (x2 >> 6);
    assign wi  = w_reg[0];
    assign sg1 = shac_pkg::rotr(v_reg[4], 14) ^ shac_pkg::rotr(v_reg[4], 18)
               ^ shac_pkg::rotr(v_reg[4], 41);
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1  = v_reg[7] + sg1 + ch + shac_pkg::round_const(rnd_reg) + wi;
    assign sg0 = shac_pkg::rotr(v_reg[0], 28) ^ shac_pkg::rotr(v_reg[0], 34)
               ^ shac_pkg::rotr(v_reg[0], 39);
    assign mj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2  = sg0 + mj;

    // Buffer is a shift line: new word enters at 15, round reads slot 0.
    always_ff @(posedge clk)
    begin
        if (cmd.take_word || cmd.push_pad)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= cmd.take_word ? in_word : pad_word;
        end
        else if (cmd.do_round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_reg[0] + s0 + w_reg[9] + s1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= '0;
                h_reg[i] <= shac_pkg::init_value(1'b0, 3'(i));
            end
            len_reg     <= '0;
            pos_reg     <= '0;
            rnd_reg     <= '0;
            idx_reg     <= '0;
            n384_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            padok_reg   <= 1'b0;
            zslot_reg   <= 1'b0;
            lendone_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_iv)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= shac_pkg::init_value(variant, 3'(i));
                n384_reg <= variant;
            end
            if (cmd.take_word)
            begin
                len_reg   <= cmd.load_iv ? {60'd0, n_clip} : len_next;
                pos_reg   <= pos_reg + 4'd1;
                pend_reg  <= final_word && n_clip == 4'd8;
                padok_reg <= final_word;
            end
            if (cmd.push_pad)
            begin
                pos_reg   <= pos_reg + 4'd1;
                pend_reg  <= 1'b0;
                zslot_reg <= (pos_reg == 4'd14) && !pend_reg;
                if (pos_reg == 4'd15 && zslot_reg)
                    lendone_reg <= 1'b1;
            end
            if (cmd.start_round)
            begin
                rnd_reg <= '0;
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            if (cmd.do_round)
            begin
                rnd_reg  <= rnd_reg + 7'd1;
                v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            if (cmd.do_add)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            if (cmd.finish)
            begin
                idx_reg     <= '0;
                pos_reg     <= '0;
                padok_reg   <= 1'b0;
                zslot_reg   <= 1'b0;
                lendone_reg <= 1'b0;
            end
            else if (cmd.emit_step)
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_comb
    begin
        stat.block_full  = (pos_reg == 4'd15);
        stat.rounds_done = (rnd_reg == 7'(shac_pkg::ROUNDS - 1));
        stat.pad_left    = padok_reg;
        // padding ends once the length word is in the block
        stat.pad_done    = lendone_reg;
        stat.emit_last   = idx_reg == (n384_reg ? 3'd5 : 3'd7);
    end

    assign digest_word      = h_reg[idx_reg];
    assign word_index       = idx_reg;
    assign last_digest_word = stat.emit_last;
endmodule

// ===== src/shac_ctrl.sv =====
// Controller state machine of the SHA-512/384 core.
`timescale 1ns / 1ps
module shac_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_final,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  shac_pkg::stat_t stat,
    output shac_pkg::cmd_t  cmd
);
    shac_pkg::state_t state_reg, state_next;
    logic started_reg, started_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= shac_pkg::ST_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        unique case (state_reg)
            shac_pkg::ST_IDLE:
                if (in_valid)
                begin
                    started_next = !in_final;
                    if (stat.block_full)
                        state_next = shac_pkg::ST_ROUND;
                    else if (in_final)
                        state_next = shac_pkg::ST_PAD;
                end
            shac_pkg::ST_PAD:
                if (stat.block_full)
                    state_next = shac_pkg::ST_ROUND;
            shac_pkg::ST_ROUND:
                if (stat.rounds_done)
                    state_next = shac_pkg::ST_ADD;
            shac_pkg::ST_ADD:
                if (stat.pad_left && stat.pad_done)
                    state_next = shac_pkg::ST_EMIT;
                else if (stat.pad_left)
                    state_next = shac_pkg::ST_PAD;
                else
                    state_next = shac_pkg::ST_IDLE;
            shac_pkg::ST_EMIT:
                if (out_ready && stat.emit_last)
                    state_next = shac_pkg::ST_IDLE;
            default:
                state_next = shac_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            shac_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_word = in_valid;
                cmd.load_iv   = in_valid && !started_reg;
                cmd.start_round = in_valid && stat.block_full;
            end
            shac_pkg::ST_PAD:
            begin
                cmd.push_pad    = 1'b1;
                cmd.start_round = stat.block_full;
            end
            shac_pkg::ST_ROUND:
                cmd.do_round = 1'b1;
            shac_pkg::ST_ADD:
                cmd.do_add = 1'b1;
            shac_pkg::ST_EMIT:
            begin
                out_valid     = 1'b1;
                cmd.emit_step = out_ready;
                cmd.finish    = out_ready && stat.emit_last;
            end
            default: ;
        endcase
    end
endmodule

// ===== src/sha512_sha384_hash_core.sv =====
// Top level of the SHA-512/384 hash core.
//
//  channel   dir  payload                                   handshake
//  in        in   message_word[63:0] byte_count[3:0] final  valid/ready
//  result    out  digest_word[63:0] word_index[2:0] last    valid/ready
//  cfg       in   data (variant: 0 SHA-512, 1 SHA-384)      valid/ready
//
// One request is taken per cycle while a block fills; the sixteenth word of a
// block starts 80 rounds of the single round unit, then the result folds into
// the chain value, and no request is taken until that is done.
// A final word adds the padding words, one per cycle, and one or two
// compressions, then the digest words are offered one per cycle while the
// receiver is ready. Reset loads the SHA-512 initial values and clears the
// variant; a stalled result holds until taken.
`timescale 1ns / 1ps
module sha512_sha384_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    shac_in_if.sink     in_ch,
    shac_out_if.source  out_ch,
    shac_cfg_if.sink    cfg
);
    shac_pkg::cmd_t  cmd;
    shac_pkg::stat_t stat;
    logic            variant_reg;

    // Variant is sampled at message start, so a write is always safe.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            variant_reg <= 1'b0;
        else if (cfg.valid)
            variant_reg <= cfg.data;
    end

    shac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_final (in_ch.final_word),
        .in_ready (in_ch.ready),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    shac_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .variant         (variant_reg),
        .message_word    (in_ch.message_word),
        .byte_count      (in_ch.byte_count),
        .final_word      (in_ch.final_word),
        .digest_word     (out_ch.digest_word),
        .word_index      (out_ch.word_index),
        .last_digest_word(out_ch.last_digest_word)
    );
endmodule

// ===== src/shac_checker.sv =====
// Port checker of the SHA-512/384 core, bound to the top level.
`timescale 1ns / 1ps
module shac_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] word_index,
    input logic       last_digest_word
);
    // No request taken while a digest is offered.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input open during digest");
    // Digest words count up by one.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_digest_word |=> out_valid
        && word_index == $past(word_index) + 3'd1) else $error("digest index skip");
    // Digest starts at index zero.
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> word_index == 3'd0) else $error("digest start index");
    // Last word is index 5 or 7.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_digest_word |-> word_index == 3'd5 || word_index == 3'd7)
        else $error("bad last index");
endmodule

bind sha512_sha384_hash_core shac_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .word_index      (out_ch.word_index),
    .last_digest_word(out_ch.last_digest_word)
);

// ===== verif/tb_sha512_sha384_hash_core.sv =====
// Testbench of the SHA-512/384 hash core: random and directed messages, local digest model.
`timescale 1ns / 1ps
module tb_sha512_sha384_hash_core;

    localparam int CYCLE_LIMIT = 400000;

    // One request on the message channel
    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } msg_req_t;

    // One digest word expected on the result channel
    typedef struct {
        logic [63:0] value;
        logic [2:0]  index;
        logic        last;
    } digest_exp_t;

    logic clk;
    logic rst_n;

    shac_in_if  in_ch ();
    shac_out_if out_ch ();
    shac_cfg_if cfg ();

    sha512_sha384_hash_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    msg_req_t    pending_reqs[$];
    digest_exp_t expected_digest[$];

    // Local copy of the hash state
    logic        hash_variant;
    logic [63:0] hash_chain[8];
    logic [63:0] hash_block[16];
    logic [63:0] hash_len;
    int          hash_pos;
    logic        hash_busy;

    int  error_count;
    int  cycle_count;
    bit  drain_pause;   // sender holds off until all digests are in
    bit  hold_results;  // receiver holds off for a long stretch
    int  hold_cycles;
    bit  no_idle;
    bit  cfg_req;
    bit  cfg_value;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] rot_right(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Run the 80 rounds over the current block and fold into the chain value
    task automatic compress_block();
        logic [63:0] w[16];
        logic [63:0] v[8];
        logic [63:0] x15, x2, wi, s0, s1, t1, t2;
        for (int j = 0; j < 16; j++)
            w[j] = hash_block[j];
        for (int j = 0; j < 8; j++)
            v[j] = hash_chain[j];
        for (int i = 0; i < shac_pkg::ROUNDS; i++)
        begin
            if (i < 16)
                wi = w[i];
            else
            begin
                x15 = w[(i - 15) & 15];
                x2  = w[(i - 2) & 15];
                s0 = rot_right(x15, 1) ^ rot_right(x15, 8) ^ (x15 >> 7);
                s1 = rot_right(x2, 19) ^ rot_right(x2, 61) ^ (x2 >> 6);
                wi = w[i & 15] + s0 + w[(i - 7) & 15] + s1;
                w[i & 15] = wi;
            end
            t1 = v[7] + (rot_right(v[4], 14) ^ rot_right(v[4], 18) ^ rot_right(v[4], 41))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shac_pkg::round_const(7'(i)) + wi;
            t2 = (rot_right(v[0], 28) ^ rot_right(v[0], 34) ^ rot_right(v[0], 39))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hash_chain[j] = hash_chain[j] + v[j];
    endtask

    task automatic append_word(input logic [63:0] w);
        hash_block[hash_pos] = w;
        hash_pos = (hash_pos + 1) % 16;
        if (hash_pos == 0)
            compress_block();
    endtask

    // Advance the hash state by one accepted request; queue the digest on a final word
    task automatic hash_accept(input msg_req_t r);
        int          n;
        int          count;
        logic [63:0] keep;
        digest_exp_t e;
        if (!hash_busy)
        begin
            for (int j = 0; j < 8; j++)
                hash_chain[j] = shac_pkg::init_value(hash_variant, 3'(j));
            hash_len  = '0;
            hash_pos  = 0;
            hash_busy = 1'b1;
        end
        if (!r.last)
        begin
            hash_len += 8;
            append_word(r.word);
        end
        else
        begin
            n = (r.nbytes > 8) ? 8 : int'(r.nbytes);
            hash_len += n;
            if (n == 8)
            begin
                append_word(r.word);
                append_word({shac_pkg::PAD_BYTE, 56'h0});
            end
            else
            begin
                keep = (n == 0) ? 64'h0 : ~64'h0 << (64 - 8 * n);
                append_word((r.word & keep) | ({56'h0, shac_pkg::PAD_BYTE} << (56 - 8 * n)));
            end
            while (hash_pos != shac_pkg::LEN_SLOT)
                append_word('0);
            append_word('0);
            append_word(hash_len << 3);
            count = hash_variant ? 6 : 8;
            for (int i = 0; i < count; i++)
            begin
                e.value = hash_chain[i];
                e.index = 3'(i);
                e.last  = (i == count - 1);
                expected_digest.push_back(e);
            end
            hash_busy = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Driver: offer the oldest pending request, with random idle cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.message_word <= '0;
            in_ch.byte_count   <= '0;
            in_ch.final_word   <= 1'b0;
            cfg.valid          <= 1'b0;
            cfg.data           <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                hash_variant = cfg.data;
                cfg_req      = 1'b0;
            end
            if (in_ch.valid && in_ch.ready)
                hash_accept(pending_reqs.pop_front());
            cfg.valid <= cfg_req;
            cfg.data  <= cfg_value;
            // Hold a request that is still waiting
            if (in_ch.valid && !in_ch.ready)
                in_ch.valid <= 1'b1;
            else if (pending_reqs.size() > 0 && !drain_pause && !cfg_req
                     && (no_idle || $urandom_range(99) >= 11))
            begin
                in_ch.valid        <= 1'b1;
                in_ch.message_word <= pending_reqs[0].word;
                in_ch.byte_count   <= pending_reqs[0].nbytes;
                in_ch.final_word   <= pending_reqs[0].last;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Monitor: compare accepted digest words, stall the receiver at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_digest.size() == 0)
                begin
                    report_mismatch("unexpected digest word", out_ch.digest_word, '0);
                end
                else
                begin
                    digest_exp_t e;
                    e = expected_digest.pop_front();
                    if (out_ch.digest_word !== e.value)
                        report_mismatch("digest_word", out_ch.digest_word, e.value);
                    if (out_ch.word_index !== e.index)
                        report_mismatch("word_index", 64'(out_ch.word_index), 64'(e.index));
                    if (out_ch.last_digest_word !== e.last)
                        report_mismatch("last_digest_word", 64'(out_ch.last_digest_word),
                                        64'(e.last));
                end
            end
            // Hold off the results for a long stretch when asked
            if (hold_results && hold_cycles < 600)
            begin
                hold_cycles  <= hold_cycles + 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= no_idle || $urandom_range(99) >= 11;
        end
    end

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Queue one message of the given length in bytes
    task automatic queue_message(input int nbytes, input bit ragged_count);
        msg_req_t r;
        int       full;
        full = nbytes / 8;
        for (int i = 0; i < full; i++)
        begin
            r.word   = {$urandom, $urandom};
            r.nbytes = ragged_count ? 4'($urandom) : 4'd8;
            r.last   = (i == full - 1) && (nbytes % 8 == 0) && $urandom_range(1);
            pending_reqs.push_back(r);
            if (r.last)
                return;
        end
        r.word   = {$urandom, $urandom};
        r.nbytes = 4'(nbytes % 8);
        r.last   = 1'b1;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_ch.valid || expected_digest.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_variant(input bit v);
        cfg_value = v;
        cfg_req   = 1'b1;
        while (cfg_req)
            @(posedge clk);
    endtask

    initial
    begin
        msg_req_t r;
        error_count  = 0;
        cycle_count  = 0;
        drain_pause  = 1'b0;
        hold_results = 1'b0;
        no_idle      = 1'b0;
        cfg_req      = 1'b0;
        cfg_value    = 1'b0;
        hash_variant = 1'b0;
        hash_busy    = 1'b0;
        hash_pos     = 0;
        hash_len     = '0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty message, extreme words, byte counts past eight, exact blocks
        r.word = '0;        r.nbytes = 4'd0;  r.last = 1'b1; pending_reqs.push_back(r);
        r.word = '1;        r.nbytes = 4'd8;  r.last = 1'b1; pending_reqs.push_back(r);
        r.word = '1;        r.nbytes = 4'd15; r.last = 1'b1; pending_reqs.push_back(r);
        r.word = '1;        r.nbytes = 4'd9;  r.last = 1'b1; pending_reqs.push_back(r);
        for (int n = 1; n < 8; n++)
        begin
            r.word = '1; r.nbytes = 4'(n); r.last = 1'b1; pending_reqs.push_back(r);
        end
        // A non-final word with an odd count, which counts as eight bytes
        r.word = 64'h0123456789abcdef; r.nbytes = 4'd3; r.last = 1'b0;
        pending_reqs.push_back(r);
        r.word = '0;        r.nbytes = 4'd0;  r.last = 1'b1; pending_reqs.push_back(r);
        queue_message(112, 1'b0);
        queue_message(128, 1'b0);
        wait_drained();

        // SHA-384 messages
        write_variant(1'b1);
        queue_message(0, 1'b0);
        queue_message(111, 1'b1);
        queue_message(120, 1'b0);
        wait_drained();

        // Random messages over both variants; one long phase with no idling
        for (int phase = 0; phase < 6; phase++)
        begin
            no_idle = (phase == 2);
            write_variant(phase[0]);
            for (int m = 0; m < 2; m++)
                queue_message(($urandom_range(3) == 0) ? $urandom_range(120, 200)
                              : $urandom_range(0, 40), $urandom_range(1));
            if (phase == 3)
            begin
                // Long receiver hold so the core backs up and stalls its input
                hold_results = 1'b1;
                while (hold_cycles < 600)
                    @(posedge clk);
                hold_results = 1'b0;
            end
            if (phase == 4)
            begin
                // Pause the sender until every digest has been taken
                while (pending_reqs.size() > 2)
                    @(posedge clk);
                drain_pause = 1'b1;
                while (in_ch.valid || expected_digest.size() > 0)
                    @(posedge clk);
                drain_pause = 1'b0;
            end
            wait_drained();
        end
        no_idle = 1'b0;

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
